FILE: rtl/core/tgc_pkg.sv
// tgc_pkg: shared constants, codes and structs of the touch gesture classifier
// used by every module under rtl/core; depends on nothing

`default_nettype none

package tgc_pkg;

	localparam int COORD_BITS = 10;
	localparam int REG_BITS   = 10;
	localparam int CMP_BITS   = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
	localparam int DATA_BITS  = 32;
	localparam int ADDR_BITS  = 5;
	localparam int IDX_BITS   = ADDR_BITS - 2;

	localparam logic [IDX_BITS-1:0] REG_SWIPE_THR   = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] REG_CLICK_THR   = IDX_BITS'(1);
	localparam logic [IDX_BITS-1:0] REG_SCREEN_H    = IDX_BITS'(2);
	localparam logic [IDX_BITS-1:0] REG_TOP_BAND    = IDX_BITS'(3);
	localparam logic [IDX_BITS-1:0] REG_BOTTOM_BAND = IDX_BITS'(4);

	localparam logic [REG_BITS-1:0] RST_SWIPE_THR   = REG_BITS'(80);
	localparam logic [REG_BITS-1:0] RST_CLICK_THR   = REG_BITS'(10);
	localparam logic [REG_BITS-1:0] RST_SCREEN_H    = REG_BITS'(240);
	localparam logic [REG_BITS-1:0] RST_TOP_BAND    = REG_BITS'(15);
	localparam logic [REG_BITS-1:0] RST_BOTTOM_BAND = REG_BITS'(20);

	typedef enum logic [2:0] {
		GEST_NONE  = 3'd0,
		GEST_LEFT  = 3'd1,
		GEST_RIGHT = 3'd2,
		GEST_UP    = 3'd3,
		GEST_DOWN  = 3'd4,
		GEST_CLICK = 3'd5
	} gesture_t;

	typedef struct packed {
		logic [REG_BITS-1:0] swipe_thr;
		logic [REG_BITS-1:0] click_thr;
		logic [REG_BITS-1:0] screen_h;
		logic [REG_BITS-1:0] top_band;
		logic [REG_BITS-1:0] bottom_band;
	} cfg_t;

	typedef struct packed {
		logic                  pressed;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} sample_t;

	typedef struct packed {
		logic                  was_pressed;
		logic                  swipe_done;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] held_x;
		logic [COORD_BITS-1:0] held_y;
	} track_t;

endpackage

`default_nettype wire

FILE: rtl/core/touch_gesture_classifier_top.sv
// touch_gesture_classifier_top: top level of the touch gesture classifier
// depends on tgc_pkg, tgc_cfg_regs and tgc_classify
//
// usage
//   in channel: in_valid/in_ready with pressed, touch_x, touch_y, one touch sample
//   per item. out channel: out_valid/out_ready with gesture, last_pos_x,
//   last_pos_y, exactly one result item per input item, in order.
//   gesture codes: 0 none, 1 left, 2 right, 3 up, 4 down, 5 click.
//   apb-style port: five 10-bit registers at byte addresses 0,4,8,12,16
//   (swipe threshold, click threshold, screen height, top band, bottom band);
//   write them only while no item is in flight. pready is always high.
//   path: an accepted item passes the input register, then the result register,
//   and is valid at the output once it sits in the result register.
//   throughput: one item per cycle while out_ready stays high, set by the
//   combinational classification step between the two registers.
//   stall: when a result waits and out_ready is low the result register holds, the
//   input register fills, and in_ready drops; nothing is lost or repeated.
//   reset: asynchronous, active-low arst_n clears both valid flags, the touch
//   state (no touch in progress, last position 0) and loads register defaults.

`default_nettype none

module touch_gesture_classifier_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           pressed,
	input  wire logic [tgc_pkg::COORD_BITS-1:0] touch_x,
	input  wire logic [tgc_pkg::COORD_BITS-1:0] touch_y,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output tgc_pkg::gesture_t                   gesture,
	output logic      [tgc_pkg::COORD_BITS-1:0] last_pos_x,
	output logic      [tgc_pkg::COORD_BITS-1:0] last_pos_y,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [tgc_pkg::ADDR_BITS-1:0]  paddr,
	input  wire logic [tgc_pkg::DATA_BITS-1:0]  pwdata,
	output logic      [tgc_pkg::DATA_BITS-1:0]  prdata,
	output logic                                pready
);
	import tgc_pkg::*;

	cfg_t                  cfg;
	logic                  vld_s1;
	sample_t               smp_s1;
	logic                  vld_s2;
	gesture_t              gest_s2;
	logic [COORD_BITS-1:0] pos_x_s2;
	logic [COORD_BITS-1:0] pos_y_s2;
	track_t                trk_q;
	track_t                trk_nxt;
	gesture_t              gest_nxt;
	logic                  adv;
	logic                  take;

	tgc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tgc_classify u_cls (
		.smp  (smp_s1),
		.cur  (trk_q),
		.cfg  (cfg),
		.gest (gest_nxt),
		.nxt  (trk_nxt)
	);

	assign adv      = vld_s1 & (~vld_s2 | out_ready);
	assign in_ready = ~vld_s1 | adv;
	assign take     = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			smp_s1.pressed <= pressed;
			smp_s1.x       <= touch_x;
			smp_s1.y       <= touch_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2            <= 1'b0;
			trk_q.was_pressed <= 1'b0;
			trk_q.swipe_done  <= 1'b0;
			trk_q.start_x     <= '0;
			trk_q.start_y     <= '0;
			trk_q.held_x      <= '0;
			trk_q.held_y      <= '0;
		end else begin
			if (adv) begin
				vld_s2            <= 1'b1;
				trk_q.was_pressed <= trk_nxt.was_pressed;
				trk_q.swipe_done  <= trk_nxt.swipe_done;
				trk_q.start_x     <= trk_nxt.start_x;
				trk_q.start_y     <= trk_nxt.start_y;
				trk_q.held_x      <= trk_nxt.held_x;
				trk_q.held_y      <= trk_nxt.held_y;
			end else if (out_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gest_s2  <= gest_nxt;
			pos_x_s2 <= trk_nxt.held_x;
			pos_y_s2 <= trk_nxt.held_y;
		end
	end

	assign out_valid  = vld_s2;
	assign gesture    = gest_s2;
	assign last_pos_x = pos_x_s2;
	assign last_pos_y = pos_y_s2;

endmodule

`default_nettype wire

FILE: rtl/core/tgc_cfg_regs.sv
// tgc_cfg_regs: configuration registers of the classifier behind an apb-style port
// depends on tgc_pkg

`default_nettype none

module tgc_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tgc_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [tgc_pkg::DATA_BITS-1:0] pwdata,
	output logic      [tgc_pkg::DATA_BITS-1:0] prdata,
	output logic                               pready,
	output tgc_pkg::cfg_t                      cfg
);
	import tgc_pkg::*;

	logic                wr_en;
	logic [IDX_BITS-1:0] idx;
	logic [REG_BITS-1:0] wval;
	logic [REG_BITS-1:0] rval;
	cfg_t                cfg_q;

	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ADDR_BITS-1:2];
	assign wval   = pwdata[REG_BITS-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.swipe_thr   <= RST_SWIPE_THR;
			cfg_q.click_thr   <= RST_CLICK_THR;
			cfg_q.screen_h    <= RST_SCREEN_H;
			cfg_q.top_band    <= RST_TOP_BAND;
			cfg_q.bottom_band <= RST_BOTTOM_BAND;
		end else if (wr_en) begin
			case (idx)
				REG_SWIPE_THR:   cfg_q.swipe_thr   <= wval;
				REG_CLICK_THR:   cfg_q.click_thr   <= wval;
				REG_SCREEN_H:    cfg_q.screen_h    <= wval;
				REG_TOP_BAND:    cfg_q.top_band    <= wval;
				REG_BOTTOM_BAND: cfg_q.bottom_band <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SWIPE_THR:   rval = cfg_q.swipe_thr;
			REG_CLICK_THR:   rval = cfg_q.click_thr;
			REG_SCREEN_H:    rval = cfg_q.screen_h;
			REG_TOP_BAND:    rval = cfg_q.top_band;
			REG_BOTTOM_BAND: rval = cfg_q.bottom_band;
			default:         rval = '0;
		endcase
		prdata = DATA_BITS'(rval);
	end

endmodule

`default_nettype wire

FILE: rtl/core/tgc_classify.sv
// tgc_classify: one classification step, from a sample and the touch state to the
// gesture code and the next touch state; depends on tgc_pkg

`default_nettype none

module tgc_classify (
	input  wire tgc_pkg::sample_t smp,
	input  wire tgc_pkg::track_t  cur,
	input  wire tgc_pkg::cfg_t    cfg,
	output tgc_pkg::gesture_t     gest,
	output tgc_pkg::track_t       nxt
);
	import tgc_pkg::*;

	logic signed [COORD_BITS:0]   dx;
	logic signed [COORD_BITS:0]   dy;
	logic        [COORD_BITS-1:0] ax;
	logic        [COORD_BITS-1:0] ay;
	logic        [CMP_BITS-1:0]   ax_w;
	logic        [CMP_BITS-1:0]   ay_w;
	logic        [CMP_BITS-1:0]   sy_w;
	logic signed [REG_BITS:0]     band_lo;
	logic signed [CMP_BITS+1:0]   band_lo_w;
	logic signed [CMP_BITS+1:0]   sy_s;
	logic                         in_band;
	logic                         horiz;
	logic                         vert;
	logic                         click;

	always_comb begin
		dx = signed'({1'b0, smp.x}) - signed'({1'b0, cur.start_x});
		dy = signed'({1'b0, smp.y}) - signed'({1'b0, cur.start_y});
		ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		ax_w = CMP_BITS'(ax);
		ay_w = CMP_BITS'(ay);
		sy_w = CMP_BITS'(cur.start_y);

		// bottom band starts at screen height minus band size, may go negative
		band_lo   = signed'({1'b0, cfg.screen_h}) - signed'({1'b0, cfg.bottom_band});
		band_lo_w = (CMP_BITS+2)'(band_lo);
		sy_s      = signed'((CMP_BITS+2)'(cur.start_y));
		in_band   = (sy_w <= CMP_BITS'(cfg.top_band)) |
			((sy_s >= band_lo_w) & (sy_w <= CMP_BITS'(cfg.screen_h)));

		horiz = (ax_w > ay_w) & (ax_w > CMP_BITS'(cfg.swipe_thr));
		vert  = (ay_w > ax_w) & (ay_w > CMP_BITS'(cfg.swipe_thr)) & in_band;
		click = (ax_w < CMP_BITS'(cfg.click_thr)) & (ay_w < CMP_BITS'(cfg.click_thr));

		gest = GEST_NONE;
		nxt  = cur;
		if (smp.pressed) begin
			if (!cur.was_pressed) begin
				nxt.start_x    = smp.x;
				nxt.start_y    = smp.y;
				nxt.swipe_done = 1'b0;
			end else if (!cur.swipe_done) begin
				if (horiz) begin
					gest = dx[COORD_BITS] ? GEST_LEFT : GEST_RIGHT;
				end else if (vert) begin
					gest = dy[COORD_BITS] ? GEST_UP : GEST_DOWN;
				end
			end
			nxt.held_x = smp.x;
			nxt.held_y = smp.y;
		end else begin
			// start point is valid exactly while the previous sample was pressed
			if (cur.was_pressed && click) begin
				gest = GEST_CLICK;
			end
			nxt.swipe_done = 1'b0;
		end
		nxt.was_pressed = smp.pressed;
		if (gest != GEST_NONE) begin
			nxt.swipe_done = 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/tgc_checker.sv
// tgc_checker: port-level checks of touch_gesture_classifier_top, bound to it
// depends on tgc_pkg and touch_gesture_classifier_top

`default_nettype none

module tgc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire tgc_pkg::gesture_t              gesture,
	input wire logic [tgc_pkg::COORD_BITS-1:0] last_pos_x,
	input wire logic [tgc_pkg::COORD_BITS-1:0] last_pos_y,
	input wire logic                           pready
);
	import tgc_pkg::*;

	// the output is valid once an accepted item has passed the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("accepted item did not reach the output");

	// backpressure on the input only comes from a stalled output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// a stalled result item holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gesture)
			&& $stable(last_pos_x) && $stable(last_pos_y))
		else $error("stalled result item changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind touch_gesture_classifier_top tgc_checker u_tgc_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: self-checking bench for touch_gesture_classifier_top, random touch traffic
// against an in-bench gesture predictor; depends on tgc_pkg and the rtl/core sources

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tgc_pkg::*;

	typedef struct packed {
		gesture_t              code;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} touch_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  pressed = 1'b0;
	logic [COORD_BITS-1:0] touch_x = '0;
	logic [COORD_BITS-1:0] touch_y = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	gesture_t              gesture;
	logic [COORD_BITS-1:0] last_pos_x;
	logic [COORD_BITS-1:0] last_pos_y;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_BITS-1:0]  paddr = '0;
	logic [DATA_BITS-1:0]  pwdata = '0;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	sample_t       sample_queue[$];
	touch_result_t gesture_queue[$];
	int            errors = 0;
	bit            idle_on = 1'b1;
	logic          in_fire = 1'b0;
	int            in_gap = 0;
	int            out_gap = 0;
	sample_t       next_sample;

	// predictor state and register copy
	logic [REG_BITS-1:0]   regs [0:4] = '{RST_SWIPE_THR, RST_CLICK_THR, RST_SCREEN_H,
		RST_TOP_BAND, RST_BOTTOM_BAND};
	int                    org_x = -1;
	int                    org_y = -1;
	bit                    was_down = 1'b0;
	bit                    swiped = 1'b0;
	logic [COORD_BITS-1:0] hold_x = '0;
	logic [COORD_BITS-1:0] hold_y = '0;

	touch_gesture_classifier_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pressed   (pressed),
		.touch_x   (touch_x),
		.touch_y   (touch_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.gesture   (gesture),
		.last_pos_x(last_pos_x),
		.last_pos_y(last_pos_y),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic touch_result_t classify_touch(sample_t s);
		touch_result_t r;
		int dx, dy, ax, ay, thr, height, lo;
		bit band;
		gesture_t g;
		g = GEST_NONE;
		thr = int'(regs[REG_SWIPE_THR]);
		if (s.pressed) begin
			if (!was_down) begin
				org_x = int'(s.x);
				org_y = int'(s.y);
				swiped = 1'b0;
			end else if (!swiped) begin
				dx = int'(s.x) - org_x;
				dy = int'(s.y) - org_y;
				ax = (dx < 0) ? -dx : dx;
				ay = (dy < 0) ? -dy : dy;
				height = int'(regs[REG_SCREEN_H]);
				lo = height - int'(regs[REG_BOTTOM_BAND]);
				band = (org_y >= 0 && org_y <= int'(regs[REG_TOP_BAND])) ||
					(org_y >= lo && org_y <= height);
				if (ax > ay && ax > thr) begin
					g = (dx > 0) ? GEST_RIGHT : GEST_LEFT;
				end else if (ay > ax && ay > thr && band) begin
					g = (dy > 0) ? GEST_DOWN : GEST_UP;
				end
			end
			hold_x = s.x;
			hold_y = s.y;
		end else begin
			if (was_down && org_x >= 0 && org_y >= 0) begin
				dx = int'(s.x) - org_x;
				dy = int'(s.y) - org_y;
				ax = (dx < 0) ? -dx : dx;
				ay = (dy < 0) ? -dy : dy;
				if (ax < int'(regs[REG_CLICK_THR]) && ay < int'(regs[REG_CLICK_THR])) begin
					g = GEST_CLICK;
				end
			end
			org_x = -1;
			org_y = -1;
			swiped = 1'b0;
		end
		was_down = s.pressed;
		if (g != GEST_NONE) begin
			swiped = 1'b1;
		end
		r.code = g;
		r.x = hold_x;
		r.y = hold_y;
		return r;
	endfunction

	// input driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (in_gap > 0) begin
				in_gap = in_gap - 1;
				in_valid <= 1'b0;
			end else if (sample_queue.size() > 0) begin
				next_sample = sample_queue.pop_front();
				in_valid <= 1'b1;
				pressed <= next_sample.pressed;
				touch_x <= next_sample.x;
				touch_y <= next_sample.y;
				if (idle_on && $urandom_range(0, 5) == 0) begin
					in_gap = $urandom_range(1, 10);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap = out_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0) begin
					out_gap = $urandom_range(1, 10);
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : check_results
		touch_result_t want;
		sample_t s;
		in_fire <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			s.pressed = pressed;
			s.x = touch_x;
			s.y = touch_y;
			gesture_queue.push_back(classify_touch(s));
		end
		if (arst_n && out_valid && out_ready) begin
			if (gesture_queue.size() == 0) begin
				$error("result item with none expected: gesture %0d", gesture);
				errors++;
			end else begin
				want = gesture_queue.pop_front();
				if (gesture !== want.code) begin
					$error("gesture: expected %0d, actual %0d", want.code, gesture);
					errors++;
				end
				if (last_pos_x !== want.x) begin
					$error("last_pos_x: expected %0d, actual %0d", want.x, last_pos_x);
					errors++;
				end
				if (last_pos_y !== want.y) begin
					$error("last_pos_y: expected %0d, actual %0d", want.y, last_pos_y);
					errors++;
				end
			end
		end
	end

	function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
		if (v < 0) begin
			return '0;
		end
		if (v > (1 << COORD_BITS) - 1) begin
			return '1;
		end
		return COORD_BITS'(v);
	endfunction

	function automatic int signed_offset(int span);
		int v;
		v = $urandom_range(0, span);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	task automatic push_sample(input bit p, input int x, input int y);
		sample_t s;
		s.pressed = p;
		s.x = clamp_coord(x);
		s.y = clamp_coord(y);
		sample_queue.push_back(s);
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input int value);
		logic [DATA_BITS-1:0] data;
		data = $urandom;
		data[REG_BITS-1:0] = value[REG_BITS-1:0];
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx <= REG_BOTTOM_BAND) begin
			regs[idx] = data[REG_BITS-1:0];
		end
	endtask

	task automatic check_reg(input logic [IDX_BITS-1:0] idx);
		logic [DATA_BITS-1:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== DATA_BITS'(regs[idx])) begin
			$error("prdata reg %0d: expected %0d, actual %0d", idx, regs[idx], got);
			errors++;
		end
	endtask

	task automatic set_config(input int swipe, input int click, input int height,
		input int top, input int bottom);
		write_reg(REG_SWIPE_THR, swipe);
		write_reg(REG_CLICK_THR, click);
		write_reg(REG_SCREEN_H, height);
		write_reg(REG_TOP_BAND, top);
		write_reg(REG_BOTTOM_BAND, bottom);
		for (int i = REG_BOTTOM_BAND + 1; i < 2 ** IDX_BITS; i++) begin
			write_reg(IDX_BITS'(i), $urandom);
		end
		for (int i = 0; i <= REG_BOTTOM_BAND; i++) begin
			check_reg(IDX_BITS'(i));
		end
	endtask

	task automatic wait_drain();
		while (sample_queue.size() != 0 || in_valid || gesture_queue.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// mostly well-formed touches: press, a few moves, release; some noise items
	task automatic queue_touches(input int count);
		int made, sx, sy, cx, cy, moves, thr, ct, bb, h, travel;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 9) == 0) begin
				push_sample($urandom_range(0, 1), $urandom_range(0, 1023),
					$urandom_range(0, 1023));
				made++;
			end else begin
				thr = int'(regs[REG_SWIPE_THR]);
				ct = int'(regs[REG_CLICK_THR]);
				bb = int'(regs[REG_BOTTOM_BAND]);
				h = int'(regs[REG_SCREEN_H]);
				sx = $urandom_range(0, 1023);
				case ($urandom_range(0, 2))
					0: begin
						sy = $urandom_range(0, int'(regs[REG_TOP_BAND]) + 4);
					end
					1: begin
						sy = h - bb - 4 + int'($urandom_range(0, bb + 8));
					end
					default: begin
						sy = $urandom_range(0, 1023);
					end
				endcase
				sx = clamp_coord(sx);
				sy = clamp_coord(sy);
				push_sample(1'b1, sx, sy);
				moves = $urandom_range(0, 5);
				repeat (moves) begin
					travel = signed_offset(thr + 120);
					case ($urandom_range(0, 3))
						0: begin
							cx = sx + travel;
							cy = sy + signed_offset(40);
						end
						1: begin
							cx = sx + signed_offset(40);
							cy = sy + travel;
						end
						2: begin
							cx = sx + travel;
							cy = sy + ($urandom_range(0, 1) ? travel : -travel);
						end
						default: begin
							cx = $urandom_range(0, 1023);
							cy = $urandom_range(0, 1023);
						end
					endcase
					push_sample(1'b1, cx, cy);
				end
				if ($urandom_range(0, 1)) begin
					push_sample(1'b0, sx + signed_offset(ct + 2), sy + signed_offset(ct + 2));
				end else begin
					push_sample(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023));
				end
				made += moves + 2;
			end
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// register defaults, directed touches
		push_sample(1'b0, 0, 0);
		push_sample(1'b1, 500, 100);
		push_sample(1'b1, 581, 100);
		push_sample(1'b1, 700, 100);
		push_sample(1'b0, 900, 100);
		push_sample(1'b1, 500, 100);
		push_sample(1'b1, 419, 100);
		push_sample(1'b0, 419, 100);
		push_sample(1'b1, 5, 5);
		push_sample(1'b1, 5, 200);
		push_sample(1'b0, 5, 5);
		push_sample(1'b1, 10, 230);
		push_sample(1'b1, 10, 100);
		push_sample(1'b0, 10, 100);
		push_sample(1'b1, 300, 100);
		push_sample(1'b1, 300, 300);
		push_sample(1'b1, 390, 190);
		push_sample(1'b0, 300, 100);
		push_sample(1'b1, 50, 50);
		push_sample(1'b1, 52, 53);
		push_sample(1'b0, 59, 41);
		push_sample(1'b0, 50, 50);
		push_sample(1'b1, 0, 0);
		push_sample(1'b1, 1023, 0);
		push_sample(1'b0, 0, 1023);
		push_sample(1'b1, 1023, 1023);
		push_sample(1'b0, 1023, 1023);
		wait_drain();

		set_config(0, 0, 1, 0, 0);
		queue_touches(220);
		wait_drain();
		set_config(1023, 1023, 1023, 1023, 1023);
		queue_touches(220);
		wait_drain();
		// bottom band reaching below zero
		set_config(100, 30, 100, 20, 600);
		queue_touches(220);
		wait_drain();
		repeat (4) begin
			idle_on = ($urandom_range(0, 3) != 0);
			set_config($urandom_range(0, 300), $urandom_range(0, 60), $urandom_range(1, 1023),
				$urandom_range(0, 200), $urandom_range(0, 300));
			queue_touches(250);
			wait_drain();
		end
		idle_on = 1'b0;
		set_config(RST_SWIPE_THR, RST_CLICK_THR, RST_SCREEN_H, RST_TOP_BAND, RST_BOTTOM_BAND);
		queue_touches(300);
		wait_drain();

		repeat (6) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
